@@ design/lfpd_pkg.sv @@
package lfpd_pkg;

  // Sensor array geometry.
  localparam int SENSOR_COUNT = 8;
  localparam int READING_BITS = 10;
  localparam int LOG_SENSORS  = $clog2(SENSOR_COUNT);

  // Fixed point formats.
  localparam int FRAC_BITS  = 8;
  localparam int SUM_BITS   = READING_BITS + LOG_SENSORS;
  localparam int WSUM_BITS  = READING_BITS + $clog2(SENSOR_COUNT * (SENSOR_COUNT - 1) / 2);
  localparam int QUO_BITS   = LOG_SENSORS + FRAC_BITS;
  localparam int ERR_BITS   = QUO_BITS;
  localparam int DER_BITS   = ERR_BITS + 1;
  localparam int INTEG_BITS = 24;
  localparam int GAIN_BITS  = 16;
  localparam int SPEED_BITS = 11;
  localparam int OUT_BITS   = 13;
  localparam int ACC_BITS   = GAIN_BITS + INTEG_BITS + 1;
  localparam int DRV_BITS   = ACC_BITS - FRAC_BITS;

  // Line center in Q.8: (SENSOR_COUNT - 1) / 2.
  localparam int CENTER = (SENSOR_COUNT - 1) << (FRAC_BITS - 1);

  // Configuration port.
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic signed [GAIN_BITS-1:0] PROP_GAIN_RST  = 16'sd26;
  localparam logic signed [GAIN_BITS-1:0] INTEG_GAIN_RST = 16'sd26;
  localparam logic signed [GAIN_BITS-1:0] DERIV_GAIN_RST = 16'sd0;
  localparam logic [SPEED_BITS-1:0]       BASE_SPEED_RST  = 11'd804;
  localparam logic [SPEED_BITS-1:0]       DRIVE_LIMIT_RST = 11'd804;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_BASE_SPEED  = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } cfg_reg_t;

  typedef logic [READING_BITS-1:0] reading_t;

  // Centroid unit to PID unit: one-cycle pulse with the line error.
  typedef struct packed {
    logic                       valid;
    logic                       lost;
    logic signed [ERR_BITS-1:0] error;
  } cen_res_t;

  // PID unit to output stage: held until taken.
  typedef struct packed {
    logic                       valid;
    logic                       lost;
    logic                       clamped;
    logic signed [OUT_BITS-1:0] left;
    logic signed [OUT_BITS-1:0] right;
  } pid_res_t;

endpackage

@@ design/lfpd_centroid.sv @@
module lfpd_centroid
  import lfpd_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  reading_t [SENSOR_COUNT-1:0]       readings,
  output cen_res_t                          result
);

  localparam int SCNT_BITS = $clog2(SENSOR_COUNT);
  localparam int QCNT_BITS = $clog2(QUO_BITS);

  typedef enum logic [1:0] {C_IDLE, C_ACC, C_DIV} cen_state_t;

  cen_state_t                  state;
  reading_t [SENSOR_COUNT-1:0] shift;
  logic [SCNT_BITS-1:0]        scount;
  logic [QCNT_BITS-1:0]        qcount;
  logic [SUM_BITS-1:0]         sum;
  logic [SUM_BITS-1:0]         sum_next;
  logic [WSUM_BITS-1:0]        wsum;
  logic [SUM_BITS-1:0]         rem;
  logic [SUM_BITS-1:0]         rem_next;
  logic [QUO_BITS-1:0]         nq;
  logic [QUO_BITS-1:0]         nq_next;
  logic [SUM_BITS+1:0]         trial;
  logic                        qbit;

  // Running sum; each prefix sum adds once more to the weighted sum.
  assign sum_next = sum + SUM_BITS'(shift[0]);

  // One restoring division step: bring down the next numerator bit and try the subtract.
  assign trial    = {1'b0, rem, nq[QUO_BITS-1]} - {2'b00, sum};
  assign qbit     = ~trial[SUM_BITS+1];
  assign rem_next = qbit ? trial[SUM_BITS-1:0] : {rem[SUM_BITS-2:0], nq[QUO_BITS-1]};
  assign nq_next  = {nq[QUO_BITS-2:0], qbit};

  // Sequencer: one reading a cycle, then one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= C_IDLE;
      result.valid <= 1'b0;
    end else begin
      // The result pulses for one cycle after the last quotient bit.
      result.valid <= (state == C_DIV) && (qcount == QCNT_BITS'(QUO_BITS - 1));
      unique case (state)
        C_IDLE: begin
          if (start) begin
            shift  <= readings;
            sum    <= '0;
            wsum   <= '0;
            scount <= '0;
            state  <= C_ACC;
          end
        end
        C_ACC: begin
          shift  <= shift >> READING_BITS;
          sum    <= sum_next;
          scount <= scount + SCNT_BITS'(1);
          if (scount == SCNT_BITS'(SENSOR_COUNT - 1)) begin
            // Numerator is wsum shifted up by FRAC_BITS; its top part seeds the remainder.
            rem    <= SUM_BITS'(wsum >> LOG_SENSORS);
            nq     <= {wsum[LOG_SENSORS-1:0], FRAC_BITS'(0)};
            qcount <= '0;
            state  <= C_DIV;
          end else begin
            wsum <= wsum + WSUM_BITS'(sum_next);
          end
        end
        C_DIV: begin
          rem    <= rem_next;
          nq     <= nq_next;
          qcount <= qcount + QCNT_BITS'(1);
          if (qcount == QCNT_BITS'(QUO_BITS - 1)) begin
            // With no light on any sensor the error is forced to zero.
            result.lost  <= (sum == '0);
            result.error <= (sum == '0) ? '0 : ERR_BITS'(nq_next - QUO_BITS'(CENTER));
            state        <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

@@ design/lfpd_pid.sv @@
module lfpd_pid
  import lfpd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  cen_res_t                    cen,
  input  logic                        take,
  input  logic signed [GAIN_BITS-1:0] prop_gain,
  input  logic signed [GAIN_BITS-1:0] integ_gain,
  input  logic signed [GAIN_BITS-1:0] deriv_gain,
  input  logic [SPEED_BITS-1:0]       base_speed,
  input  logic [SPEED_BITS-1:0]       drive_limit,
  output pid_res_t                    result
);

  localparam int BCNT_BITS = $clog2(GAIN_BITS);

  typedef enum logic [1:0] {P_IDLE, P_MAC, P_CLAMP, P_HOLD} pid_state_t;
  typedef enum logic [1:0] {PROD_P, PROD_I, PROD_D} prod_t;

  pid_state_t                   state;
  prod_t                        prod;
  logic [BCNT_BITS-1:0]         bitcnt;
  logic [GAIN_BITS-1:0]         gain_sr;
  logic signed [ACC_BITS-1:0]   mcand;
  logic signed [ACC_BITS-1:0]   acc;
  logic signed [ACC_BITS-1:0]   addend;
  logic signed [ACC_BITS-1:0]   acc_next;
  logic signed [INTEG_BITS-1:0] integ;
  logic signed [INTEG_BITS-1:0] integ_next;
  logic signed [INTEG_BITS:0]   integ_sum;
  logic signed [ERR_BITS-1:0]   prev_err;
  logic signed [DER_BITS-1:0]   deriv;
  logic signed [DER_BITS-1:0]   deriv_next;
  logic signed [DRV_BITS-1:0]   drv;
  logic signed [DRV_BITS-1:0]   lim_pos;
  logic signed [DRV_BITS-1:0]   lim_neg;
  logic signed [SPEED_BITS:0]   drive;
  logic                         lost;
  logic                         clamped;

  // Error history update.
  assign deriv_next = {cen.error[ERR_BITS-1], cen.error} - {prev_err[ERR_BITS-1], prev_err};
  assign integ_sum  = {integ[INTEG_BITS-1], integ}
                    + {{(INTEG_BITS+1-ERR_BITS){cen.error[ERR_BITS-1]}}, cen.error};

  // Saturate the integrator when the sum leaves the 24-bit range.
  always_comb begin
    if (integ_sum[INTEG_BITS] != integ_sum[INTEG_BITS-1]) begin
      integ_next = integ_sum[INTEG_BITS] ? {1'b1, {(INTEG_BITS-1){1'b0}}}
                                         : {1'b0, {(INTEG_BITS-1){1'b1}}};
    end else begin
      integ_next = integ_sum[INTEG_BITS-1:0];
    end
  end

  // Shift-and-add over the gain bits; the sign bit of the gain has negative weight.
  assign addend   = (bitcnt == BCNT_BITS'(GAIN_BITS - 1)) ? -mcand : mcand;
  assign acc_next = gain_sr[0] ? acc + addend : acc;

  // Q.16 to Q.8 with an arithmetic shift rounds toward minus infinity.
  assign drv     = acc[ACC_BITS-1:FRAC_BITS];
  assign lim_pos = $signed({{(DRV_BITS-SPEED_BITS){1'b0}}, drive_limit});
  assign lim_neg = -lim_pos;

  // Control loop sequencer and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= P_IDLE;
      integ    <= '0;
      prev_err <= '0;
    end else begin
      unique case (state)
        P_IDLE: begin
          if (cen.valid) begin
            prev_err <= cen.error;
            deriv    <= deriv_next;
            integ    <= integ_next;
            lost     <= cen.lost;
            acc      <= '0;
            prod     <= PROD_P;
            bitcnt   <= '0;
            gain_sr  <= prop_gain;
            mcand    <= {{(ACC_BITS-ERR_BITS){cen.error[ERR_BITS-1]}}, cen.error};
            state    <= P_MAC;
          end
        end
        P_MAC: begin
          acc <= acc_next;
          if (bitcnt == BCNT_BITS'(GAIN_BITS - 1)) begin
            // Move on to the next gain and its operand, or to the clamp after the last gain.
            bitcnt <= '0;
            unique case (prod)
              PROD_P: begin
                prod    <= PROD_I;
                gain_sr <= integ_gain;
                mcand   <= {{(ACC_BITS-INTEG_BITS){integ[INTEG_BITS-1]}}, integ};
              end
              PROD_I: begin
                prod    <= PROD_D;
                gain_sr <= deriv_gain;
                mcand   <= {{(ACC_BITS-DER_BITS){deriv[DER_BITS-1]}}, deriv};
              end
              default: state <= P_CLAMP;
            endcase
          end else begin
            gain_sr <= gain_sr >> 1;
            mcand   <= mcand << 1;
            bitcnt  <= bitcnt + BCNT_BITS'(1);
          end
        end
        P_CLAMP: begin
          // Reaching the limit exactly does not count as clamped.
          priority if (drv > lim_pos) begin
            drive   <= $signed({1'b0, drive_limit});
            clamped <= 1'b1;
          end else if (drv < lim_neg) begin
            drive   <= -$signed({1'b0, drive_limit});
            clamped <= 1'b1;
          end else begin
            drive   <= drv[SPEED_BITS:0];
            clamped <= 1'b0;
          end
          state <= P_HOLD;
        end
        P_HOLD: begin
          if (take) begin
            state <= P_IDLE;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  // Wheel speeds, wrapped to the output width.
  assign result.valid   = (state == P_HOLD);
  assign result.lost    = lost;
  assign result.clamped = clamped;
  assign result.left    = {{(OUT_BITS-SPEED_BITS){1'b0}}, base_speed}
                        + {{(OUT_BITS-SPEED_BITS-1){drive[SPEED_BITS]}}, drive};
  assign result.right   = {{(OUT_BITS-SPEED_BITS){1'b0}}, base_speed}
                        - {{(OUT_BITS-SPEED_BITS-1){drive[SPEED_BITS]}}, drive};

endmodule

@@ design/line_follow_pid_drive.sv @@
// Channel    Handshake                    Payload
// frame      frame_valid / frame_stall    reading_0 .. reading_7
// drive      drive_valid / drive_stall    left_wheel, right_wheel, line_lost, drive_clamped
// config     cfg_we                       cfg_index, cfg_data
//
// A frame's result moves into the output register after running sums (one reading a
// cycle), restoring division (one quotient bit a cycle), a hand-off, bit-serial
// multiply-accumulate (three 16-bit gains, one gain bit a cycle) and a clamp; the
// move waits while the output register holds a stalled result.
// Reset is synchronous and active high; it restores the gains and speeds and clears
// the integrator and the last error. frame_stall is high from a frame transfer until
// its result moves into the output register; a stalled result holds there while the
// next frame is taken.
module line_follow_pid_drive
  import lfpd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         frame_valid,
  output logic                         frame_stall,
  input  logic [READING_BITS-1:0]      reading_0,
  input  logic [READING_BITS-1:0]      reading_1,
  input  logic [READING_BITS-1:0]      reading_2,
  input  logic [READING_BITS-1:0]      reading_3,
  input  logic [READING_BITS-1:0]      reading_4,
  input  logic [READING_BITS-1:0]      reading_5,
  input  logic [READING_BITS-1:0]      reading_6,
  input  logic [READING_BITS-1:0]      reading_7,
  output logic                         drive_valid,
  input  logic                         drive_stall,
  output logic signed [OUT_BITS-1:0]   left_wheel,
  output logic signed [OUT_BITS-1:0]   right_wheel,
  output logic                         line_lost,
  output logic                         drive_clamped,
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data
);

  logic signed [GAIN_BITS-1:0] prop_gain;
  logic signed [GAIN_BITS-1:0] integ_gain;
  logic signed [GAIN_BITS-1:0] deriv_gain;
  logic [SPEED_BITS-1:0]       base_speed;
  logic [SPEED_BITS-1:0]       drive_limit;
  logic                        busy;
  logic                        frame_xfer;
  logic                        load;
  reading_t [SENSOR_COUNT-1:0] readings;
  cen_res_t                    cen_res;
  pid_res_t                    pid_res;

  assign readings = {reading_7, reading_6, reading_5, reading_4,
                     reading_3, reading_2, reading_1, reading_0};

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= PROP_GAIN_RST;
      integ_gain  <= INTEG_GAIN_RST;
      deriv_gain  <= DERIV_GAIN_RST;
      base_speed  <= BASE_SPEED_RST;
      drive_limit <= DRIVE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:   prop_gain   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        REG_BASE_SPEED:  base_speed  <= cfg_data[SPEED_BITS-1:0];
        REG_DRIVE_LIMIT: drive_limit <= cfg_data[SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

  // One frame in flight at a time.
  assign frame_stall = busy;
  assign frame_xfer  = frame_valid && !busy;
  assign load        = pid_res.valid && (!drive_valid || !drive_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (frame_xfer) begin
      busy <= 1'b1;
    end else if (load) begin
      busy <= 1'b0;
    end
  end

  lfpd_centroid u_centroid (
    .clk      (clk),
    .rst      (rst),
    .start    (frame_xfer),
    .readings (readings),
    .result   (cen_res)
  );

  lfpd_pid u_pid (
    .clk         (clk),
    .rst         (rst),
    .cen         (cen_res),
    .take        (load),
    .prop_gain   (prop_gain),
    .integ_gain  (integ_gain),
    .deriv_gain  (deriv_gain),
    .base_speed  (base_speed),
    .drive_limit (drive_limit),
    .result      (pid_res)
  );

  // Output register: a finished result waits here for its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (load) begin
      drive_valid <= 1'b1;
    end else if (!drive_stall) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_wheel    <= pid_res.left;
      right_wheel   <= pid_res.right;
      line_lost     <= pid_res.lost;
      drive_clamped <= pid_res.clamped;
    end
  end

  // The centroid unit only reports for a frame that was taken.
  a_cen_in_frame: assert property (@(posedge clk) disable iff (rst)
    cen_res.valid |-> busy)
    else $error("centroid result outside a frame");

  // The PID unit only holds a result while its frame is still open.
  a_pid_in_frame: assert property (@(posedge clk) disable iff (rst)
    pid_res.valid |-> busy)
    else $error("PID result outside a frame");

  // A result moves to the output register exactly once.
  a_single_load: assert property (@(posedge clk) disable iff (rst)
    load |=> !pid_res.valid)
    else $error("PID result offered again after load");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import lfpd_pkg::*;

  localparam int CLK_HIGH         = 6;
  localparam int CLK_LOW          = 6;
  localparam int RESET_CYCLES     = 7;
  localparam int QUIET_LIMIT      = 4000;
  localparam int LONG_HOLD        = 500;
  localparam int HOLD_FRAMES      = 12;
  localparam int WINDUP_FRAMES    = 24;
  localparam int DRAIN_CYCLES     = 120;
  localparam int RANDOM_PHASES    = 8;
  localparam int FRAMES_PER_PHASE = 160;
  localparam int READING_MAX      = (1 << READING_BITS) - 1;
  localparam int LINE_MID         = (SENSOR_COUNT - 1) << (FRAC_BITS - 1);
  localparam longint INTEG_MAX    = (longint'(1) <<< (INTEG_BITS - 1)) - 1;
  localparam longint INTEG_MIN    = -(longint'(1) <<< (INTEG_BITS - 1));
  localparam logic [CFG_BITS-1:0] UNITY_GAIN  = CFG_BITS'(1 << FRAC_BITS);
  localparam logic [CFG_BITS-1:0] MAX_GAIN    = 16'h7FFF;
  localparam logic [CFG_BITS-1:0] MIN_GAIN    = 16'h8000;
  localparam logic [CFG_BITS-1:0] ALL_ONES    = 16'hFFFF;
  localparam logic [CFG_BITS-1:0] SPEED_ZERO  = 16'hF800;
  localparam logic [CFG_BITS-1:0] MID_SPEED   = 16'd1024;

  typedef reading_t frame_t [SENSOR_COUNT];

  typedef struct {
    logic signed [OUT_BITS-1:0] left;
    logic signed [OUT_BITS-1:0] right;
    logic                       lost;
    logic                       clamped;
  } wheel_cmd_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       frame_valid;
  logic                       frame_stall;
  frame_t                     rd;
  logic                       drive_valid;
  logic                       drive_stall;
  logic signed [OUT_BITS-1:0] left_wheel;
  logic signed [OUT_BITS-1:0] right_wheel;
  logic                       line_lost;
  logic                       drive_clamped;
  logic                       cfg_we;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [CFG_BITS-1:0]        cfg_data;

  // Shadow copy of the steering registers and the controller state.
  logic signed [GAIN_BITS-1:0] kp, ki, kd;
  logic [SPEED_BITS-1:0]       base_spd, drv_lim;
  longint                      integ_acc, last_err;

  wheel_cmd_t pending_cmds [$];
  bit         tx_gaps, rx_gaps, long_hold_req;
  int         mismatches = 0;
  int         frames_taken = 0;
  int         results_checked = 0;
  int         cfg_writes = 0;

  line_follow_pid_drive uut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .reading_0    (rd[0]),
    .reading_1    (rd[1]),
    .reading_2    (rd[2]),
    .reading_3    (rd[3]),
    .reading_4    (rd[4]),
    .reading_5    (rd[5]),
    .reading_6    (rd[6]),
    .reading_7    (rd[7]),
    .drive_valid  (drive_valid),
    .drive_stall  (drive_stall),
    .left_wheel   (left_wheel),
    .right_wheel  (right_wheel),
    .line_lost    (line_lost),
    .drive_clamped(drive_clamped),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW clk = 1'b0;
  end

  // Centroid, error, PID and clamp for one frame; advances the controller state.
  function automatic wheel_cmd_t steer_frame(input frame_t frame);
    longint     total, moment, err, slope, raw, drv, lim, base;
    wheel_cmd_t cmd;
    total = 0;
    moment = 0;
    err = 0;
    cmd.clamped = 1'b0;
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      total += longint'(frame[k]);
      moment += longint'(frame[k]) * (SENSOR_COUNT - 1 - k);
    end
    cmd.lost = (total == 0);
    if (!cmd.lost) begin
      err = ((moment << FRAC_BITS) / total) - LINE_MID;
    end
    slope = err - last_err;
    integ_acc += err;
    if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
    if (integ_acc < INTEG_MIN) integ_acc = INTEG_MIN;
    last_err = err;
    raw = longint'(kp) * err + longint'(ki) * integ_acc + longint'(kd) * slope;
    drv = raw >>> FRAC_BITS;
    lim = drv_lim;
    base = base_spd;
    if (drv > lim) begin
      drv = lim;
      cmd.clamped = 1'b1;
    end
    if (drv < -lim) begin
      drv = -lim;
      cmd.clamped = 1'b1;
    end
    cmd.left = OUT_BITS'(base + drv);
    cmd.right = OUT_BITS'(base - drv);
    return cmd;
  endfunction

  task automatic check_field(input string field, input logic signed [OUT_BITS-1:0] want,
                             input logic signed [OUT_BITS-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Predict on each frame transfer; check each drive transfer against the oldest prediction.
  always @(posedge clk) begin : observe
    wheel_cmd_t want;
    if (!rst && frame_valid && !frame_stall) begin
      pending_cmds.push_back(steer_frame(rd));
      frames_taken++;
    end
    if (!rst && drive_valid && !drive_stall) begin
      results_checked++;
      if (pending_cmds.size() == 0) begin
        $error("drive transfer with no frame waiting for it");
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("left_wheel", want.left, left_wheel);
        check_field("right_wheel", want.right, right_wheel);
        check_field("line_lost", want.lost, line_lost);
        check_field("drive_clamped", want.clamped, drive_clamped);
      end
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 0;
    if (pick < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Drive side: random stalls, or one long hold-off on request.
  initial begin : wheel_sink
    drive_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        drive_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
        drive_stall = 1'b1;
        repeat (idle_len() + 1) @(negedge clk);
      end
      drive_stall = 1'b0;
    end
  end

  // End the run if nothing moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (frame_valid && !frame_stall) || (drive_valid && !drive_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one frame and hold it until its transfer; valid stays high afterward.
  task automatic send_frame(input frame_t frame);
    int gap;
    gap = tx_gaps ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      frame_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rd = frame;
    frame_valid = 1'b1;
    do @(posedge clk); while (frame_stall);
  endtask

  // Stop offering frames and wait until every predicted result has come back.
  task automatic await_drain();
    @(negedge clk);
    frame_valid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_PROP_GAIN:   kp = val;
      REG_INTEG_GAIN:  ki = val;
      REG_DERIV_GAIN:  kd = val;
      REG_BASE_SPEED:  base_spd = val[SPEED_BITS-1:0];
      REG_DRIVE_LIMIT: drv_lim = val[SPEED_BITS-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return MAX_GAIN;
      1: return MIN_GAIN;
      2: return '0;
      3: return CFG_BITS'($urandom);
      default: return CFG_BITS'($urandom_range(0, 1024) - 512);
    endcase
  endfunction

  // Speeds keep random upper data bits, which the block must drop.
  function automatic logic [CFG_BITS-1:0] pick_speed();
    logic [CFG_BITS-1:0] val;
    val = CFG_BITS'($urandom);
    case ($urandom_range(0, 5))
      0: return val & ~CFG_BITS'(11'h7FF);
      1: return val | CFG_BITS'(11'h7FF);
      default: return val;
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int     pick, spot;
    f = '{default: '0};
    pick = $urandom_range(0, 19);
    spot = $urandom_range(0, SENSOR_COUNT - 1);
    if (pick < 12) begin
      // A line under one sensor, spilling onto its neighbors, over faint background.
      foreach (f[k]) f[k] = $urandom_range(0, 1) ? reading_t'($urandom_range(0, 40)) : '0;
      f[spot] = reading_t'($urandom_range(300, READING_MAX));
      if (spot > 0) f[spot - 1] = reading_t'($urandom_range(0, f[spot]));
      if (spot < SENSOR_COUNT - 1) f[spot + 1] = reading_t'($urandom_range(0, f[spot]));
    end else if (pick < 17) begin
      foreach (f[k]) f[k] = reading_t'($urandom_range(0, READING_MAX));
    end else if (pick < 18) begin
      f[spot] = reading_t'($urandom_range(1, READING_MAX));
    end else if (pick < 19) begin
      f = '{default: reading_t'(READING_MAX)};
    end
    return f;
  endfunction

  // Reset values of all registers: edges of the sensor range and line loss.
  task automatic test_reset_values();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_frame('{default: '0});
    send_frame('{default: reading_t'(READING_MAX)});
    send_frame('{READING_MAX, 0, 0, 0, 0, 0, 0, 0});
    send_frame('{0, 0, 0, 0, 0, 0, 0, READING_MAX});
    // Losing the line right after a hard turn clears the last error.
    send_frame('{default: '0});
    send_frame('{0, 0, 0, 512, 512, 0, 0, 0});
    send_frame('{1, 0, 0, 0, 0, 0, 0, 0});
    send_frame('{10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155});
    send_frame('{10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA});
    await_drain();
  endtask

  // A drive of exactly the limit is not clamped; one past it is. Unused indexes do nothing.
  task automatic test_limit_edge();
    frame_t err_up, err_down;
    err_up = '{0, 0, 0, 228, 28, 0, 0, 0};
    err_down = '{0, 0, 0, 28, 228, 0, 0, 0};
    write_reg(REG_PROP_GAIN, UNITY_GAIN);
    write_reg(REG_INTEG_GAIN, '0);
    write_reg(REG_DERIV_GAIN, '0);
    write_reg(REG_BASE_SPEED, MID_SPEED);
    write_reg(REG_DRIVE_LIMIT, 16'd100);
    send_frame(err_up);
    send_frame(err_down);
    await_drain();
    write_reg(REG_DRIVE_LIMIT, 16'd99);
    send_frame(err_up);
    send_frame(err_down);
    await_drain();
    write_reg(REG_DRIVE_LIMIT, '0);
    send_frame(err_up);
    send_frame('{default: '0});
    await_drain();
    for (int i = REG_DRIVE_LIMIT + 1; i < (1 << CFG_INDEX_BITS); i++) begin
      write_reg(CFG_INDEX_BITS'(i), ALL_ONES);
    end
    send_frame(err_up);
    await_drain();
  endtask

  // Full-scale gains and the speed extremes at both ends of the output range.
  task automatic test_gain_extremes();
    write_reg(REG_PROP_GAIN, MAX_GAIN);
    write_reg(REG_INTEG_GAIN, MIN_GAIN);
    write_reg(REG_DERIV_GAIN, MAX_GAIN);
    write_reg(REG_BASE_SPEED, ALL_ONES);
    write_reg(REG_DRIVE_LIMIT, ALL_ONES);
    send_frame('{READING_MAX, 0, 0, 0, 0, 0, 0, 0});
    send_frame('{0, 0, 0, 0, 0, 0, 0, READING_MAX});
    send_frame('{default: '0});
    send_frame('{0, 0, 0, 300, 300, 0, 0, 0});
    await_drain();
    write_reg(REG_PROP_GAIN, MIN_GAIN);
    write_reg(REG_INTEG_GAIN, MAX_GAIN);
    write_reg(REG_DERIV_GAIN, MIN_GAIN);
    write_reg(REG_BASE_SPEED, SPEED_ZERO);
    send_frame('{0, 0, 0, 0, 0, 0, 0, READING_MAX});
    send_frame('{READING_MAX, 0, 0, 0, 0, 0, 0, 0});
    await_drain();
  endtask

  // Random settings per phase, cycling through every mix of sender and receiver idling.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      await_drain();
      write_reg(REG_PROP_GAIN, pick_gain());
      write_reg(REG_INTEG_GAIN, pick_gain());
      write_reg(REG_DERIV_GAIN, pick_gain());
      write_reg(REG_BASE_SPEED, pick_speed());
      write_reg(REG_DRIVE_LIMIT, pick_speed());
      tx_gaps = (phase % 4) < 2;
      rx_gaps = (phase % 2) == 0;
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if ($urandom_range(0, 63) == 0) await_drain();
        send_frame(random_frame());
      end
    end
    await_drain();
  endtask

  // The drive side holds off long enough for the block to fill and stall frames.
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    long_hold_req = 1'b1;
    repeat (HOLD_FRAMES) send_frame(random_frame());
    await_drain();
  endtask

  // Wind the integral up with the line hard to one side, then pull it back the other way.
  task automatic test_integral_windup();
    frame_t hard_right, hard_left;
    hard_right = '{READING_MAX, 0, 0, 0, 0, 0, 0, 0};
    hard_left = '{0, 0, 0, 0, 0, 0, 0, READING_MAX};
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_reg(REG_PROP_GAIN, '0);
    write_reg(REG_INTEG_GAIN, CFG_BITS'(1));
    write_reg(REG_DERIV_GAIN, '0);
    write_reg(REG_BASE_SPEED, MID_SPEED);
    write_reg(REG_DRIVE_LIMIT, ALL_ONES);
    repeat (WINDUP_FRAMES) send_frame(hard_right);
    await_drain();
    write_reg(REG_PROP_GAIN, MIN_GAIN);
    repeat (WINDUP_FRAMES) send_frame(hard_left);
    await_drain();
  endtask

  initial begin
    rst = 1'b1;
    frame_valid = 1'b0;
    rd = '{default: '0};
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    long_hold_req = 1'b0;
    kp = PROP_GAIN_RST;
    ki = INTEG_GAIN_RST;
    kd = DERIV_GAIN_RST;
    base_spd = BASE_SPEED_RST;
    drv_lim = DRIVE_LIMIT_RST;
    integ_acc = 0;
    last_err = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_limit_edge();
    test_gain_extremes();
    test_random_traffic();
    test_backpressure();
    test_integral_windup();

    await_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d frames and checked %0d drive results over %0d register writes.",
             frames_taken, results_checked, cfg_writes);
    $display("Included line loss, limit edges, gain extremes, backpressure, integrator windup.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
